// File: hw/rtl/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg: shared types and constants of the velocity command protector
// Register map, reset values and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package vcp_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR_SPEED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_STEP_LIMIT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP_LIMIT    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD_SQ = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_THRESHOLD_SQ  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FREEZE_TICKS       = 8'd7;

    // Reset values
    localparam logic [14:0] RST_MAX_LINEAR_SPEED   = 15'd2048;
    localparam logic [14:0] RST_MAX_TURN_RATE      = 15'd3217;
    localparam logic [14:0] RST_LINEAR_STEP_LIMIT  = 15'd20;
    localparam logic [14:0] RST_TURN_STEP_LIMIT    = 15'd30;
    localparam logic [16:0] RST_DECAY_FACTOR       = 17'd60000;
    localparam logic [31:0] RST_ACCEL_THRESHOLD_SQ = 32'd3221225472;
    localparam logic [31:0] RST_GYRO_THRESHOLD_SQ  = 32'd3221225472;
    localparam logic [15:0] RST_FREEZE_TICKS       = 16'd100;

    // Q1.16 unity
    localparam logic [16:0] DECAY_ONE = 17'd65536;

    typedef struct packed {
        logic [14:0] max_linear_speed;
        logic [14:0] max_turn_rate;
        logic [14:0] linear_step_limit;
        logic [14:0] turn_step_limit;
        logic [16:0] decay_factor;
        logic [31:0] accel_threshold_sq;
        logic [31:0] gyro_threshold_sq;
        logic [15:0] freeze_ticks;
    } t_cfg;

    // One accepted tick, held in the input register for the protection stage
    typedef struct packed {
        logic signed [15:0] raw_vx;
        logic signed [15:0] raw_vy;
        logic signed [15:0] raw_wz;
        logic signed [15:0] terrain_sample;
        logic               terrain_valid;
        logic               imu_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] safe_vx;
        logic signed [15:0] safe_vy;
        logic signed [15:0] safe_wz;
        logic               spike_freeze;
    } t_result;

endpackage

// File: hw/rtl/vcp_spike_det.sv
// ----------------------------------------------------------------------------
// vcp_spike_det: IMU spike detector
// Squared norms of acceleration and angular rate against their thresholds.
// ----------------------------------------------------------------------------
module vcp_spike_det (
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic               i_imu_valid,
    input  logic [31:0]        i_accel_threshold_sq,
    input  logic [31:0]        i_gyro_threshold_sq,
    output logic               o_spike
);

    logic signed [31:0] ax2, ay2, az2, gx2, gy2, gz2;
    logic [31:0]        a_norm2, g_norm2;

    // Each square is at most 2^30, so three of them fit 32 bits unsigned
    assign ax2 = i_accel_x * i_accel_x;
    assign ay2 = i_accel_y * i_accel_y;
    assign az2 = i_accel_z * i_accel_z;
    assign gx2 = i_gyro_x * i_gyro_x;
    assign gy2 = i_gyro_y * i_gyro_y;
    assign gz2 = i_gyro_z * i_gyro_z;

    assign a_norm2 = 32'(ax2[30:0]) + 32'(ay2[30:0]) + 32'(az2[30:0]);
    assign g_norm2 = 32'(gx2[30:0]) + 32'(gy2[30:0]) + 32'(gz2[30:0]);

    assign o_spike = i_imu_valid &&
                     ((a_norm2 > i_accel_threshold_sq) || (g_norm2 > i_gyro_threshold_sq));

endmodule

// File: hw/rtl/vcp_core.sv
// ----------------------------------------------------------------------------
// vcp_core: protection stage
// Holds the tick state, checks the IMU sample and computes the protected
// command for one tick.
// ----------------------------------------------------------------------------
module vcp_core #(
    parameter int TERRAIN_TIMEOUT_TICKS = 50,
    parameter int SPEED_WIDTH           = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  vcp_pkg::t_tick   i_tick,
    input  vcp_pkg::t_cfg    i_cfg,
    output vcp_pkg::t_result o_result
);

    localparam int SAT_W = (SPEED_WIDTH < 16) ? SPEED_WIDTH : 16;
    localparam logic signed [17:0] SAT_HI  = 18'((1 << (SAT_W - 1)) - 1);
    localparam logic signed [17:0] SAT_LO  = -SAT_HI - 18'sd1;
    localparam logic [15:0]        AGE_MAX = 16'hFFFF;
    localparam logic [15:0]        AGE_LIM = 16'(TERRAIN_TIMEOUT_TICKS);

    logic signed [15:0] r_last_vx, r_last_vy, r_last_wz;
    logic               r_has_output;
    logic               r_freeze_active;
    logic [15:0]        r_freeze_remaining;
    logic signed [15:0] r_terrain;
    logic [15:0]        r_terrain_age;
    logic               r_terrain_seen;

    logic signed [15:0] n_last_vx, n_last_vy, n_last_wz;
    logic               n_freeze_active;
    logic [15:0]        n_freeze_remaining;
    logic signed [15:0] n_terrain;
    logic [15:0]        n_terrain_age;
    logic               n_terrain_seen;

    logic               spike;
    logic               arm_active;
    logic [15:0]        arm_remaining;
    logic [16:0]        factor;
    logic [14:0]        terrain_mag;
    logic [14:0]        vmax;

    function automatic logic signed [15:0] f_sat(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[15:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[15:0];
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic signed [17:0] f_clamp(input logic signed [17:0] v,
                                                   input logic signed [17:0] lo,
                                                   input logic signed [17:0] hi);
        logic signed [17:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Magnitude times factor, truncated toward zero, sign restored
    function automatic logic signed [17:0] f_decay(input logic signed [15:0] prev,
                                                   input logic [16:0] f);
        logic signed [16:0] pe;
        logic [16:0]        mag;
        logic [33:0]        prod;
        logic signed [17:0] r;
        pe   = 17'(prev);
        mag  = pe[16] ? 17'(-pe) : 17'(pe);
        prod = 34'(mag) * 34'(f);
        r    = signed'({1'b0, prod[32:16]});
        return prev[15] ? -r : r;
    endfunction

    function automatic logic signed [15:0] f_axis(input logic signed [15:0] raw,
                                                  input logic [14:0]        lim,
                                                  input logic signed [15:0] prev,
                                                  input logic [14:0]        step,
                                                  input logic               frozen,
                                                  input logic               has_prev,
                                                  input logic [16:0]        f);
        logic signed [17:0] lim_s, step_s, prev_s, c, v;
        lim_s  = signed'({3'b000, lim});
        step_s = signed'({3'b000, step});
        prev_s = 18'(prev);
        c      = f_clamp(18'(raw), -lim_s, lim_s);
        if (frozen) begin
            v = f_decay(prev, f);
        end else if (has_prev) begin
            v = f_clamp(c, prev_s - step_s, prev_s + step_s);
        end else begin
            v = c;
        end
        return f_sat(v);
    endfunction

    vcp_spike_det u_spike_det (
        .i_accel_x            (i_tick.accel_x),
        .i_accel_y            (i_tick.accel_y),
        .i_accel_z            (i_tick.accel_z),
        .i_gyro_x             (i_tick.gyro_x),
        .i_gyro_y             (i_tick.gyro_y),
        .i_gyro_z             (i_tick.gyro_z),
        .i_imu_valid          (i_tick.imu_valid),
        .i_accel_threshold_sq (i_cfg.accel_threshold_sq),
        .i_gyro_threshold_sq  (i_cfg.gyro_threshold_sq),
        .o_spike              (spike)
    );

    always_comb begin
        // Spike restarts the freeze
        arm_active    = spike ? 1'b1 : r_freeze_active;
        arm_remaining = spike ? i_cfg.freeze_ticks : r_freeze_remaining;

        // Terrain sample and age
        if (i_tick.terrain_valid) begin
            n_terrain      = i_tick.terrain_sample;
            n_terrain_age  = '0;
            n_terrain_seen = 1'b1;
        end else begin
            n_terrain      = r_terrain;
            n_terrain_age  = (r_terrain_age < AGE_MAX) ? r_terrain_age + 16'd1 : r_terrain_age;
            n_terrain_seen = r_terrain_seen;
        end

        // Freeze ends when the count is used up
        n_freeze_active    = arm_active && (arm_remaining != '0);
        n_freeze_remaining = n_freeze_active ? arm_remaining - 16'd1 : arm_remaining;

        factor = !r_has_output ? vcp_pkg::DECAY_ONE :
                 (i_cfg.decay_factor > vcp_pkg::DECAY_ONE) ? vcp_pkg::DECAY_ONE :
                 i_cfg.decay_factor;

        terrain_mag = n_terrain[15] ? '0 : n_terrain[14:0];
        vmax = i_cfg.max_linear_speed;
        if (n_terrain_seen && (n_terrain_age <= AGE_LIM) && (terrain_mag < vmax)) begin
            vmax = terrain_mag;
        end

        n_last_vx = f_axis(i_tick.raw_vx, vmax, r_last_vx, i_cfg.linear_step_limit,
                           n_freeze_active, r_has_output, factor);
        n_last_vy = f_axis(i_tick.raw_vy, vmax, r_last_vy, i_cfg.linear_step_limit,
                           n_freeze_active, r_has_output, factor);
        n_last_wz = f_axis(i_tick.raw_wz, i_cfg.max_turn_rate, r_last_wz,
                           i_cfg.turn_step_limit, n_freeze_active, r_has_output, factor);

        o_result.safe_vx      = n_last_vx;
        o_result.safe_vy      = n_last_vy;
        o_result.safe_wz      = n_last_wz;
        o_result.spike_freeze = n_freeze_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_vx          <= '0;
            r_last_vy          <= '0;
            r_last_wz          <= '0;
            r_has_output       <= 1'b0;
            r_freeze_active    <= 1'b0;
            r_freeze_remaining <= '0;
            r_terrain          <= '0;
            r_terrain_age      <= '0;
            r_terrain_seen     <= 1'b0;
        end else if (i_adv) begin
            r_last_vx          <= n_last_vx;
            r_last_vy          <= n_last_vy;
            r_last_wz          <= n_last_wz;
            r_has_output       <= 1'b1;
            r_freeze_active    <= n_freeze_active;
            r_freeze_remaining <= n_freeze_remaining;
            r_terrain          <= n_terrain;
            r_terrain_age      <= n_terrain_age;
            r_terrain_seen     <= n_terrain_seen;
        end
    end

endmodule

// File: hw/rtl/velocity_command_protector.sv
// ----------------------------------------------------------------------------
// velocity_command_protector: slew-rate limiter with terrain cap and IMU freeze
// Top level: input stage, configuration registers and result register.
// ----------------------------------------------------------------------------
// Each transaction on the slave stream is one control tick and yields exactly
// one transaction on the master stream, in order. The block takes one tick per
// clock cycle while m_axis_tready stays high. An accepted tick lands in the
// input register; once the result register is free, a single pass of logic
// squares the IMU sample, compares the norms with their thresholds, applies
// the freeze, terrain cap, clamps and slew limits against the previous output
// and loads the result register. That pass closes the loop through the
// previous-output state, so it sets the one-tick-per-cycle figure. The result
// register lets a new tick enter while the last result waits for m_axis_tready.
// Write the configuration registers only while no tick is in flight; the write
// channel is always ready and indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module velocity_command_protector #(
    parameter int TERRAIN_TIMEOUT_TICKS = 50,
    parameter int SPEED_WIDTH           = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: raw_vx, raw_vy, raw_wz, terrain_sample, accel_x, accel_y, accel_z,
    //        gyro_x, gyro_y, gyro_z (16 bits each, lowest first)
    input  logic [159:0]                    s_axis_tdata,
    // tuser: terrain_valid [0], imu_valid [1]
    input  logic [1:0]                      s_axis_tuser,
    // Master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: safe_vx, safe_vy, safe_wz (16 bits each, lowest first)
    output logic [47:0]                     m_axis_tdata,
    // tuser: spike_freeze [0]
    output logic                            m_axis_tuser,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vcp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vcp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    vcp_pkg::t_cfg    r_cfg;
    vcp_pkg::t_tick   r_tick;
    vcp_pkg::t_tick   n_tick;
    vcp_pkg::t_result r_out;
    vcp_pkg::t_result n_out;
    logic             r_tick_valid;
    logic             r_out_valid;
    logic             out_free;
    logic             adv;
    logic             in_take;

    // Handshake: advance the tick into the result register when it is free
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_tick_valid && out_free;
    assign s_axis_tready = !r_tick_valid || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_tick.raw_vx         = signed'(s_axis_tdata[15:0]);
        n_tick.raw_vy         = signed'(s_axis_tdata[31:16]);
        n_tick.raw_wz         = signed'(s_axis_tdata[47:32]);
        n_tick.terrain_sample = signed'(s_axis_tdata[63:48]);
        n_tick.terrain_valid  = s_axis_tuser[0];
        n_tick.imu_valid      = s_axis_tuser[1];
        n_tick.accel_x        = signed'(s_axis_tdata[79:64]);
        n_tick.accel_y        = signed'(s_axis_tdata[95:80]);
        n_tick.accel_z        = signed'(s_axis_tdata[111:96]);
        n_tick.gyro_x         = signed'(s_axis_tdata[127:112]);
        n_tick.gyro_y         = signed'(s_axis_tdata[143:128]);
        n_tick.gyro_z         = signed'(s_axis_tdata[159:144]);
    end

    vcp_core #(
        .TERRAIN_TIMEOUT_TICKS (TERRAIN_TIMEOUT_TICKS),
        .SPEED_WIDTH           (SPEED_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_tick   (r_tick),
        .i_cfg    (r_cfg),
        .o_result (n_out)
    );

    // Input stage: hold the tick until it advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_valid <= 1'b0;
        end else if (in_take) begin
            r_tick_valid <= 1'b1;
        end else if (adv) begin
            r_tick_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tick <= n_tick;
        end
    end

    // Result register: hold the transaction until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.safe_wz, r_out.safe_vy, r_out.safe_vx};
    assign m_axis_tuser  = r_out.spike_freeze;

    // Configuration registers: take the low bits of the write data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_linear_speed   <= vcp_pkg::RST_MAX_LINEAR_SPEED;
            r_cfg.max_turn_rate      <= vcp_pkg::RST_MAX_TURN_RATE;
            r_cfg.linear_step_limit  <= vcp_pkg::RST_LINEAR_STEP_LIMIT;
            r_cfg.turn_step_limit    <= vcp_pkg::RST_TURN_STEP_LIMIT;
            r_cfg.decay_factor       <= vcp_pkg::RST_DECAY_FACTOR;
            r_cfg.accel_threshold_sq <= vcp_pkg::RST_ACCEL_THRESHOLD_SQ;
            r_cfg.gyro_threshold_sq  <= vcp_pkg::RST_GYRO_THRESHOLD_SQ;
            r_cfg.freeze_ticks       <= vcp_pkg::RST_FREEZE_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                vcp_pkg::REG_MAX_LINEAR_SPEED: begin
                    r_cfg.max_linear_speed <= i_cfg_data[14:0];
                end
                vcp_pkg::REG_MAX_TURN_RATE: begin
                    r_cfg.max_turn_rate <= i_cfg_data[14:0];
                end
                vcp_pkg::REG_LINEAR_STEP_LIMIT: begin
                    r_cfg.linear_step_limit <= i_cfg_data[14:0];
                end
                vcp_pkg::REG_TURN_STEP_LIMIT: begin
                    r_cfg.turn_step_limit <= i_cfg_data[14:0];
                end
                vcp_pkg::REG_DECAY_FACTOR: begin
                    r_cfg.decay_factor <= i_cfg_data[16:0];
                end
                vcp_pkg::REG_ACCEL_THRESHOLD_SQ: begin
                    r_cfg.accel_threshold_sq <= i_cfg_data[31:0];
                end
                vcp_pkg::REG_GYRO_THRESHOLD_SQ: begin
                    r_cfg.gyro_threshold_sq <= i_cfg_data[31:0];
                end
                vcp_pkg::REG_FREEZE_TICKS: begin
                    r_cfg.freeze_ticks <= i_cfg_data[15:0];
                end
                default: begin
                    // Drop writes beyond the register list
                end
            endcase
        end
    end

endmodule

// File: tb/sv/tb_velocity_command_protector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_velocity_command_protector: self-checking bench for the command protector
// Streams control ticks through the block under several register settings and
// idle patterns, predicts every protected command in-bench and compares each
// output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_velocity_command_protector;

    localparam int TERRAIN_TIMEOUT = 50;
    localparam int SPEED_W         = 16;
    localparam int NUM_PHASES      = 8;
    // Input and result registers; give them a comfortable margin before touching registers
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Indexes past the register list; the block must drop these writes
    localparam logic [vcp_pkg::CFG_IDX_W-1:0] REG_PAST_END  = 8'd8;
    localparam logic [vcp_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    // Idle pattern per phase: none, sender only, receiver only, both
    localparam int unsigned SEND_IDLE_PCT[4]  = '{0, 58, 0, 22};
    localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 58, 22};
    localparam int unsigned PHASE_TICKS[NUM_PHASES] =
        '{150, 150, 60, 300, 100, 150, 200, 200};

    // One control tick, first field in the lowest bits of the slave tdata
    typedef struct packed {
        logic               imu_valid;
        logic               terrain_valid;
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] terrain_sample;
        logic signed [15:0] raw_wz;
        logic signed [15:0] raw_vy;
        logic signed [15:0] raw_vx;
    } t_stim_tick;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [159:0]                   s_axis_tdata  = '0;
    logic [1:0]                     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [47:0]                    m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [vcp_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [vcp_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    velocity_command_protector #(
        .TERRAIN_TIMEOUT_TICKS (TERRAIN_TIMEOUT),
        .SPEED_WIDTH           (SPEED_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_stim_tick       pending_ticks[$];   // ticks not yet offered to the block
    vcp_pkg::t_result expected_cmds[$];   // protected commands still owed
    t_stim_tick       cur_tick;           // tick currently on the slave bus
    int unsigned ticks_queued   = 0;
    int unsigned cmds_seen      = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned terrain_pct    = 25;

    // Shadow registers and protection state
    vcp_pkg::t_cfg      lim;
    logic signed [15:0] prev_vx, prev_vy, prev_wz;
    logic               primed;       // at least one command has gone out
    logic               frz_on;
    logic [15:0]        frz_left;
    logic signed [15:0] terrain_cap;
    logic [15:0]        terrain_age;
    logic               terrain_seen;

    // ------------------------------------------------------------------------
    // Arithmetic helpers for the protection model
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo,
                                        input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned square16(input logic signed [15:0] v);
        longint w;
        w = longint'(v);
        return w * w;
    endfunction

    // Scale magnitude by a Q1.16 factor, truncating toward zero
    function automatic logic signed [15:0] decay_axis(input logic signed [15:0] p,
                                                      input longint unsigned f);
        longint unsigned mag;
        longint scaled;
        mag = (p < 0) ? -longint'(p) : longint'(p);
        scaled = longint'((mag * f) >> 16);
        return sat16((p < 0) ? -scaled : scaled);
    endfunction

    // Keep the new command within one step of the previous one
    function automatic logic signed [15:0] slew_axis(input longint v,
                                                     input logic signed [15:0] prev,
                                                     input logic [14:0] step);
        return sat16(clamp_to(v, longint'(prev) - longint'(step),
                              longint'(prev) + longint'(step)));
    endfunction

    // ------------------------------------------------------------------------
    // Protection model: IMU check, terrain update, then freeze or clamp+slew.
    // Pushes the protected command that the accepted tick must produce.
    // ------------------------------------------------------------------------
    task automatic protect_tick(input t_stim_tick t);
        longint unsigned acc_sq, gyr_sq, fac;
        longint vmax, wmax, cx, cy, cw;
        logic signed [15:0] nx, ny, nw;
        vcp_pkg::t_result cmd;

        if (t.imu_valid) begin
            acc_sq = square16(t.accel_x) + square16(t.accel_y) + square16(t.accel_z);
            gyr_sq = square16(t.gyro_x) + square16(t.gyro_y) + square16(t.gyro_z);
            // Strictly above threshold restarts the freeze
            if (acc_sq > lim.accel_threshold_sq || gyr_sq > lim.gyro_threshold_sq) begin
                frz_left = lim.freeze_ticks;
                frz_on   = 1'b1;
            end
        end

        if (t.terrain_valid) begin
            terrain_cap  = t.terrain_sample;
            terrain_age  = '0;
            terrain_seen = 1'b1;
        end else if (terrain_age != 16'hFFFF) begin
            terrain_age = terrain_age + 16'd1;
        end

        // Freeze expires once its count is used up; a zero length never freezes
        if (frz_on && frz_left == 16'd0)
            frz_on = 1'b0;

        if (frz_on) begin
            // No elapsed time before the first command, so no decay there
            if (!primed)
                fac = longint'(vcp_pkg::DECAY_ONE);
            else if (lim.decay_factor > vcp_pkg::DECAY_ONE)
                fac = longint'(vcp_pkg::DECAY_ONE);
            else
                fac = longint'(lim.decay_factor);
            frz_left = frz_left - 16'd1;
            nx = decay_axis(prev_vx, fac);
            ny = decay_axis(prev_vy, fac);
            nw = decay_axis(prev_wz, fac);
        end else begin
            vmax = longint'(lim.max_linear_speed);
            wmax = longint'(lim.max_turn_rate);
            // A fresh terrain sample tightens the linear cap; negative reads as zero
            if (terrain_seen && terrain_age <= TERRAIN_TIMEOUT) begin
                if (terrain_cap < 0)
                    vmax = 0;
                else if (longint'(terrain_cap) < vmax)
                    vmax = longint'(terrain_cap);
            end
            cx = clamp_to(longint'(t.raw_vx), -vmax, vmax);
            cy = clamp_to(longint'(t.raw_vy), -vmax, vmax);
            cw = clamp_to(longint'(t.raw_wz), -wmax, wmax);
            if (primed) begin
                nx = slew_axis(cx, prev_vx, lim.linear_step_limit);
                ny = slew_axis(cy, prev_vy, lim.linear_step_limit);
                nw = slew_axis(cw, prev_wz, lim.turn_step_limit);
            end else begin
                nx = sat16(cx);
                ny = sat16(cy);
                nw = sat16(cw);
            end
        end

        prev_vx = nx;
        prev_vy = ny;
        prev_wz = nw;
        primed  = 1'b1;

        cmd.safe_vx      = nx;
        cmd.safe_vy      = ny;
        cmd.safe_wz      = nw;
        cmd.spike_freeze = frz_on;
        expected_cmds.push_back(cmd);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Speeds: full range, the rails, or a band around typical limits
    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(6000) - 3000);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_imu(input logic big);
        if (!big) return 16'($urandom_range(1600) - 800);
        case ($urandom_range(3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_stim_tick random_tick();
        t_stim_tick t;
        logic  big;
        // Most IMU samples are quiet; a few carry a shock
        big = ($urandom_range(15) == 0);
        t.raw_vx         = pick_speed();
        t.raw_vy         = pick_speed();
        t.raw_wz         = pick_speed();
        t.terrain_sample = pick_speed();
        t.terrain_valid  = ($urandom_range(99) < terrain_pct);
        t.imu_valid      = 1'($urandom_range(1));
        t.accel_x        = pick_imu(big);
        t.accel_y        = pick_imu(big);
        t.accel_z        = pick_imu(big);
        t.gyro_x         = pick_imu(big);
        t.gyro_y         = pick_imu(big);
        t.gyro_z         = pick_imu(big);
        return t;
    endfunction

    task automatic push_tick(input t_stim_tick t);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic queue_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            // Alternate dense and sparse terrain so samples go stale at times
            terrain_pct = ((i / 80) % 2) ? 1 : 25;
            push_tick(random_tick());
        end
    endtask

    // Write one register over the config channel and mirror it in the shadow copy
    task automatic write_reg(input logic [vcp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vcp_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            vcp_pkg::REG_MAX_LINEAR_SPEED:   lim.max_linear_speed   = value[14:0];
            vcp_pkg::REG_MAX_TURN_RATE:      lim.max_turn_rate      = value[14:0];
            vcp_pkg::REG_LINEAR_STEP_LIMIT:  lim.linear_step_limit  = value[14:0];
            vcp_pkg::REG_TURN_STEP_LIMIT:    lim.turn_step_limit    = value[14:0];
            vcp_pkg::REG_DECAY_FACTOR:       lim.decay_factor       = value[16:0];
            vcp_pkg::REG_ACCEL_THRESHOLD_SQ: lim.accel_threshold_sq = value;
            vcp_pkg::REG_GYRO_THRESHOLD_SQ:  lim.gyro_threshold_sq  = value;
            vcp_pkg::REG_FREEZE_TICKS:       lim.freeze_ticks       = value[15:0];
            default: ;
        endcase
    endtask

    // Hold until every queued tick has come back, then let the pipeline settle
    task automatic wait_idle();
        do @(posedge i_clk); while (cmds_seen < ticks_queued);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next pending tick once the bus is free, idling at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            // A transaction completes at this edge: predict its command
            if (s_axis_tvalid)
                protect_tick(cur_tick);
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_tick = pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {cur_tick.gyro_z, cur_tick.gyro_y, cur_tick.gyro_x,
                                  cur_tick.accel_z, cur_tick.accel_y, cur_tick.accel_x,
                                  cur_tick.terrain_sample, cur_tick.raw_wz,
                                  cur_tick.raw_vy, cur_tick.raw_vx};
                s_axis_tuser  <= {cur_tick.imu_valid, cur_tick.terrain_valid};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each output transaction, stall the master side at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        vcp_pkg::t_result want;
        vcp_pkg::t_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                cmds_seen++;
                got.safe_vx      = m_axis_tdata[15:0];
                got.safe_vy      = m_axis_tdata[31:16];
                got.safe_wz      = m_axis_tdata[47:32];
                got.spike_freeze = m_axis_tuser;
                if (expected_cmds.size() == 0) begin
                    $error("command out with none expected: vx %0d vy %0d wz %0d",
                           got.safe_vx, got.safe_vy, got.safe_wz);
                    mismatches++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.safe_vx !== want.safe_vx) begin
                        $error("safe_vx: expected %0d, got %0d", want.safe_vx, got.safe_vx);
                        mismatches++;
                    end
                    if (got.safe_vy !== want.safe_vy) begin
                        $error("safe_vy: expected %0d, got %0d", want.safe_vy, got.safe_vy);
                        mismatches++;
                    end
                    if (got.safe_wz !== want.safe_wz) begin
                        $error("safe_wz: expected %0d, got %0d", want.safe_wz, got.safe_wz);
                        mismatches++;
                    end
                    if (got.spike_freeze !== want.spike_freeze) begin
                        $error("spike_freeze: expected %0d, got %0d",
                               want.spike_freeze, got.spike_freeze);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no transaction anywhere
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_velocity_command_protector NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: reset, directed ticks, then one register setting per phase
    // ------------------------------------------------------------------------
    initial begin
        t_stim_tick t;

        lim.max_linear_speed   = vcp_pkg::RST_MAX_LINEAR_SPEED;
        lim.max_turn_rate      = vcp_pkg::RST_MAX_TURN_RATE;
        lim.linear_step_limit  = vcp_pkg::RST_LINEAR_STEP_LIMIT;
        lim.turn_step_limit    = vcp_pkg::RST_TURN_STEP_LIMIT;
        lim.decay_factor       = vcp_pkg::RST_DECAY_FACTOR;
        lim.accel_threshold_sq = vcp_pkg::RST_ACCEL_THRESHOLD_SQ;
        lim.gyro_threshold_sq  = vcp_pkg::RST_GYRO_THRESHOLD_SQ;
        lim.freeze_ticks       = vcp_pkg::RST_FREEZE_TICKS;
        prev_vx      = '0;
        prev_vy      = '0;
        prev_wz      = '0;
        primed       = 1'b0;
        frz_on       = 1'b0;
        frz_left     = '0;
        terrain_cap  = '0;
        terrain_age  = '0;
        terrain_seen = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0 runs on the reset values; open with directed ticks.
        // First tick: full-scale request, clamped but not slew limited.
        t = '0;
        t.raw_vx = 16'sh7FFF;
        t.raw_vy = 16'sh8000;
        t.raw_wz = 16'sh8000;
        push_tick(t);
        // Zero request: every axis walks back by one step
        t = '0;
        push_tick(t);
        // Opposite rails
        t = '0;
        t.raw_vx = 16'sh8000;
        t.raw_vy = 16'sh7FFF;
        t.raw_wz = 16'sh7FFF;
        push_tick(t);
        // IMU norms exactly at the reset thresholds: no spike
        t.imu_valid = 1'b1;
        t.accel_x = 16'sh8000;
        t.accel_y = 16'sh8000;
        t.accel_z = 16'sh8000;
        t.gyro_x  = 16'sh8000;
        t.gyro_y  = 16'sh8000;
        t.gyro_z  = 16'sh8000;
        push_tick(t);
        t.accel_x = 16'sh7FFF;
        t.gyro_z  = 16'sh7FFF;
        push_tick(t);
        // Negative terrain sample caps linear speed at zero
        t = '0;
        t.raw_vx = 16'sh7FFF;
        t.raw_vy = 16'sh8000;
        t.terrain_valid = 1'b1;
        t.terrain_sample = -16'sd5;
        push_tick(t);
        t.terrain_sample = 16'sh8000;
        push_tick(t);
        // Small, then above-maximum terrain caps
        t.terrain_sample = 16'sd100;
        push_tick(t);
        t.terrain_sample = 16'sh7FFF;
        t.imu_valid = 1'b1;
        push_tick(t);
        // Sample held from earlier ticks, both flags low
        t.terrain_valid = 1'b0;
        t.imu_valid = 1'b0;
        for (int k = 0; k < 6; k++) begin
            t.raw_vx = (k % 2) ? 16'sh8000 : 16'sh7FFF;
            t.raw_wz = (k % 2) ? 16'sh7FFF : 16'sh8000;
            t.raw_vy = 16'sd3;
            push_tick(t);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = SEND_IDLE_PCT[p % 4];
            recv_stall_pct = RECV_STALL_PCT[p % 4];
            case (p)
                1: begin
                    // Widest limits, hair-trigger spikes, decay to zero
                    write_reg(vcp_pkg::REG_MAX_LINEAR_SPEED, 32'd32767);
                    write_reg(vcp_pkg::REG_MAX_TURN_RATE, 32'd32767);
                    write_reg(vcp_pkg::REG_LINEAR_STEP_LIMIT, 32'd32767);
                    write_reg(vcp_pkg::REG_TURN_STEP_LIMIT, 32'd32767);
                    write_reg(vcp_pkg::REG_DECAY_FACTOR, 32'd0);
                    write_reg(vcp_pkg::REG_ACCEL_THRESHOLD_SQ, 32'd0);
                    write_reg(vcp_pkg::REG_GYRO_THRESHOLD_SQ, 32'd0);
                    write_reg(vcp_pkg::REG_FREEZE_TICKS, 32'd3);
                end
                2: begin
                    // All limits zero: output pinned, spikes impossible
                    write_reg(vcp_pkg::REG_MAX_LINEAR_SPEED, 32'd0);
                    write_reg(vcp_pkg::REG_MAX_TURN_RATE, 32'd0);
                    write_reg(vcp_pkg::REG_LINEAR_STEP_LIMIT, 32'd0);
                    write_reg(vcp_pkg::REG_TURN_STEP_LIMIT, 32'd0);
                    write_reg(vcp_pkg::REG_DECAY_FACTOR, {15'd0, vcp_pkg::DECAY_ONE});
                    write_reg(vcp_pkg::REG_ACCEL_THRESHOLD_SQ, 32'hFFFF_FFFF);
                    write_reg(vcp_pkg::REG_GYRO_THRESHOLD_SQ, 32'hFFFF_FFFF);
                    write_reg(vcp_pkg::REG_FREEZE_TICKS, 32'd0);
                end
                3: begin
                    // Realistic tuning: clamps, slew and short freezes all active
                    write_reg(vcp_pkg::REG_MAX_LINEAR_SPEED, 32'd1200);
                    write_reg(vcp_pkg::REG_MAX_TURN_RATE, 32'd1600);
                    write_reg(vcp_pkg::REG_LINEAR_STEP_LIMIT, 32'd150);
                    write_reg(vcp_pkg::REG_TURN_STEP_LIMIT, 32'd200);
                    write_reg(vcp_pkg::REG_DECAY_FACTOR, 32'd52000);
                    write_reg(vcp_pkg::REG_ACCEL_THRESHOLD_SQ, 32'd6750000);
                    write_reg(vcp_pkg::REG_GYRO_THRESHOLD_SQ, 32'd4320000);
                    write_reg(vcp_pkg::REG_FREEZE_TICKS, 32'd6);
                end
                4: begin
                    // Longest freeze, decay above one; upper data bits must be dropped
                    write_reg(vcp_pkg::REG_MAX_LINEAR_SPEED, 32'h1234_8000 | 32'd900);
                    write_reg(vcp_pkg::REG_DECAY_FACTOR, 32'hFFFF_FFFF);
                    write_reg(vcp_pkg::REG_ACCEL_THRESHOLD_SQ, 32'd20000000);
                    write_reg(vcp_pkg::REG_GYRO_THRESHOLD_SQ, 32'd20000000);
                    write_reg(vcp_pkg::REG_FREEZE_TICKS, 32'hABCD_FFFF);
                end
                5: begin
                    // Zero-length freeze releases any freeze left running
                    write_reg(vcp_pkg::REG_FREEZE_TICKS, 32'd0);
                    write_reg(vcp_pkg::REG_ACCEL_THRESHOLD_SQ, 32'd0);
                    write_reg(vcp_pkg::REG_GYRO_THRESHOLD_SQ, 32'd0);
                    write_reg(vcp_pkg::REG_LINEAR_STEP_LIMIT, 32'd400);
                    write_reg(vcp_pkg::REG_TURN_STEP_LIMIT, 32'd1);
                    write_reg(REG_PAST_END, $urandom);
                    write_reg(REG_TOP_INDEX, $urandom);
                end
                6, 7: begin
                    // Random settings across the full register widths
                    write_reg(vcp_pkg::REG_MAX_LINEAR_SPEED, $urandom);
                    write_reg(vcp_pkg::REG_MAX_TURN_RATE, $urandom);
                    write_reg(vcp_pkg::REG_LINEAR_STEP_LIMIT, $urandom);
                    write_reg(vcp_pkg::REG_TURN_STEP_LIMIT, $urandom);
                    write_reg(vcp_pkg::REG_DECAY_FACTOR, $urandom);
                    write_reg(vcp_pkg::REG_ACCEL_THRESHOLD_SQ, $urandom);
                    write_reg(vcp_pkg::REG_GYRO_THRESHOLD_SQ, $urandom);
                    write_reg(vcp_pkg::REG_FREEZE_TICKS, $urandom_range(20));
                end
                default: ;
            endcase
            // Open the spike phases with a guaranteed shock
            if (p == 1 || p == 5) begin
                t = random_tick();
                t.imu_valid = 1'b1;
                t.accel_x   = 16'sh8000;
                t.gyro_z    = 16'sh7FFF;
                push_tick(t);
            end
            queue_random(PHASE_TICKS[p]);
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb_velocity_command_protector OK");
        else
            $display("tb_velocity_command_protector NOT OK");
        $finish;
    end

endmodule
